[hdl/glri_pkg.sv]
// Package for the glyph record indexer: result and error codes, limits and
// the command word that the parser hands to the result sequencer.
// No dependencies.
`timescale 1ns / 1ps

package glri_pkg;

    localparam int OFFSET_BITS_DEF = 20;
    localparam int MAX_WIDTH_DEF   = 64;

    localparam int CODE_W   = 21;
    localparam int OFFS_W   = 20;
    localparam int CMD_DEPTH = 4;

    localparam logic [23:0] CODE_LIMIT = 24'h110000;

    // Positions of the result slots in a command, in emission order.
    localparam int ITEM_CLOSE = 0;
    localparam int ITEM_GLYPH = 1;
    localparam int ITEM_FINAL = 2;
    localparam int ITEM_TAIL  = 3;
    localparam int ITEM_N     = 4;

    typedef enum logic [1:0] {
        KIND_GLYPH = 2'd0,
        KIND_RANGE = 2'd1,
        KIND_TERM  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_PREMATURE = 2'd0,
        ERR_CODE      = 2'd1,
        ERR_WIDTH     = 2'd2,
        ERR_ORDER     = 2'd3
    } err_t;

    // All results caused by one input byte. The tail slot is either the
    // terminator range or the single error result.
    typedef struct packed {
        logic [ITEM_N-1:0] items;
        logic [CODE_W-1:0] close_first;
        logic [CODE_W-1:0] close_last;
        logic [OFFS_W-1:0] glyph_offset;
        logic [CODE_W-1:0] final_first;
        logic [CODE_W-1:0] final_last;
        logic              tail_error;
        err_t              err_code;
    } cmd_t;

endpackage

[hdl/glyph_record_indexer.sv]
// Glyph record indexer top level: byte parser, command queue and result
// sequencer. Depends on glri_pkg, glri_front, glri_cmd_fifo and glri_back.
//
// Usage: table bytes enter on the s_ stream, one word per byte, with s_tlast
// on the final byte of a table. Each byte that causes results yields one to
// four result words on the m_ stream: glyph offsets, closed code point
// ranges, the terminator range and at most one error per table. m_tlast marks
// the last result word caused by one byte; m_tuser carries the result kind.
// The first result of a byte passes the queue entry and the output register.
// Throughput: one byte per cycle as long as the four-entry command queue has
// room; the sequencer drains one result word per cycle while m_tready allows,
// so a byte with several results holds the queue head until its last is loaded.
// After an error the rest of the table is consumed without results up to its
// last byte, and the next byte starts a new table.
// Reset (aresetn low at a clock edge) clears the parser state, empties the
// queue and drops m_tvalid. When the receiver holds m_tready low the output
// word is held, the queue fills behind it and s_tready then goes low.
`timescale 1ns / 1ps

module glyph_record_indexer
    import glri_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [19:0] glyph_offset, [40:20] range_first, [61:41] range_last,
    // [63:62] error_code
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] entry_kind
    output logic        m_tlast
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    cmd_t head;
    logic queue_empty;

    glri_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    glri_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    glri_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_empty (queue_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_kind   (m_tuser),
        .out_last   (m_tlast)
    );

`ifndef ASSERT_OFF
    // An error is always the only result of its byte.
    a_error_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("error result without end of run");

    // Nothing follows the terminator of a table.
    a_term_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_TERM) |-> m_tlast)
        else $error("terminator result without end of run");

    // A glyph word carries only its offset.
    a_glyph_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_GLYPH) |-> (m_tdata[63:20] == '0))
        else $error("glyph result with range or error bits set");

    // A range never runs backwards.
    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_RANGE) |-> (m_tdata[40:20] <= m_tdata[61:41]))
        else $error("range result with first above last");
`endif

endmodule

[hdl/glri_front.sv]
// Record parser: walks headers and bodies byte by byte, checks each header
// and builds one command word per byte that causes results. Uses glri_pkg.
`timescale 1ns / 1ps

module glri_front
    import glri_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_data,
    input  logic       in_last,
    output logic       in_ready,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam int BODY_W = $clog2(MAX_WIDTH * 3 + 1);

    logic [1:0]             hp_reg, hp_next;
    logic [23:0]            acc_reg, acc_next;
    logic [BODY_W-1:0]      body_reg, body_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [CODE_W-1:0]      orf_reg, orf_next;
    logic [CODE_W-1:0]      prev_reg, prev_next;
    logic                   open_reg, open_next;
    logic                   failed_reg, failed_next;

    logic        fire;
    logic        err;
    err_t        ecode;
    logic [CODE_W-1:0] cp;
    logic [9:0]  triple;
    cmd_t        cmd;

    assign in_ready = !queue_full;
    assign fire     = in_valid && in_ready;
    assign cp       = acc_reg[CODE_W-1:0];
    assign triple   = {1'b0, in_data, 1'b0} + {2'b00, in_data};

    always_comb begin
        hp_next     = hp_reg;
        acc_next    = acc_reg;
        body_next   = body_reg;
        pos_next    = pos_reg;
        orf_next    = orf_reg;
        prev_next   = prev_reg;
        open_next   = open_reg;
        failed_next = failed_reg;
        err         = 1'b0;
        ecode       = ERR_PREMATURE;
        cmd         = '0;

        if (fire && !failed_reg) begin
            pos_next = pos_reg + 1'b1;

            if (body_reg != '0) begin
                body_next = body_reg - 1'b1;
            end else if (hp_reg != 2'd3) begin
                acc_next = acc_reg | (24'(in_data) << {hp_reg, 3'b000});
                hp_next  = hp_reg + 2'd1;
            end else begin
                // Width byte: the header is complete.
                hp_next  = '0;
                acc_next = '0;
                priority if (acc_reg >= CODE_LIMIT) begin
                    err   = 1'b1;
                    ecode = ERR_CODE;
                end else if (in_data > 8'(MAX_WIDTH)) begin
                    err   = 1'b1;
                    ecode = ERR_WIDTH;
                end else if (in_last && in_data != 8'd0) begin
                    err   = 1'b1;
                    ecode = ERR_PREMATURE;
                end else if (open_reg && prev_reg >= cp) begin
                    err   = 1'b1;
                    ecode = ERR_ORDER;
                end else begin
                    // A gap in the code points closes the open range.
                    if (open_reg && ({1'b0, prev_reg} + 22'd1 < {1'b0, cp})) begin
                        cmd.items[ITEM_CLOSE] = 1'b1;
                        cmd.close_first       = orf_reg;
                        cmd.close_last        = prev_reg;
                        orf_next              = cp;
                    end
                    if (!open_reg) begin
                        orf_next = cp;
                    end
                    open_next             = 1'b1;
                    prev_next             = cp;
                    cmd.items[ITEM_GLYPH] = 1'b1;
                    cmd.glyph_offset      = OFFS_W'(pos_reg);
                    body_next             = BODY_W'(triple);
                end
            end

            if (!err && in_last) begin
                if (hp_next != '0 || body_next != '0) begin
                    err   = 1'b1;
                    ecode = ERR_PREMATURE;
                end else begin
                    if (open_next) begin
                        cmd.items[ITEM_FINAL] = 1'b1;
                        cmd.final_first       = orf_next;
                        cmd.final_last        = prev_next;
                    end
                    cmd.items[ITEM_TAIL] = 1'b1;
                end
            end

            if (err) begin
                cmd                  = '0;
                cmd.items[ITEM_TAIL] = 1'b1;
                cmd.tail_error       = 1'b1;
                cmd.err_code         = ecode;
                failed_next          = 1'b1;
            end
        end

        // The last byte of a stream always starts the next one from scratch.
        if (fire && in_last) begin
            hp_next     = '0;
            acc_next    = '0;
            body_next   = '0;
            pos_next    = '0;
            orf_next    = '0;
            prev_next   = '0;
            open_next   = 1'b0;
            failed_next = 1'b0;
        end
    end

    assign push     = fire && (cmd.items != '0);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg     <= '0;
            acc_reg    <= '0;
            body_reg   <= '0;
            pos_reg    <= '0;
            orf_reg    <= '0;
            prev_reg   <= '0;
            open_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end else begin
            hp_reg     <= hp_next;
            acc_reg    <= acc_next;
            body_reg   <= body_next;
            pos_reg    <= pos_next;
            orf_reg    <= orf_next;
            prev_reg   <= prev_next;
            open_reg   <= open_next;
            failed_reg <= failed_next;
        end
    end

endmodule

[hdl/glri_cmd_fifo.sv]
// Short command queue between the parser and the result sequencer.
// Register based, depth from glri_pkg::CMD_DEPTH (a power of two).
`timescale 1ns / 1ps

module glri_cmd_fifo
    import glri_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(CMD_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_comb begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

[hdl/glri_back.sv]
// Result sequencer: takes the queue head command apart into its results, one
// word per cycle unless out_ready stalls, into the output register. Uses glri_pkg.
`timescale 1ns / 1ps

module glri_back
    import glri_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        head,
    input  logic        head_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data,
    output logic [1:0]  out_kind,
    output logic        out_last
);

    logic [ITEM_N-1:0] done_reg, done_next;
    logic [ITEM_N-1:0] pending;
    logic [ITEM_N-1:0] sel;
    logic              final_item;
    logic              load;

    logic              valid_reg, valid_next;
    kind_t             kind_reg, kind_next;
    logic [OFFS_W-1:0] offs_reg, offs_next;
    logic [CODE_W-1:0] first_reg, first_next;
    logic [CODE_W-1:0] lastcp_reg, lastcp_next;
    err_t              err_reg, err_next;
    logic              eor_reg, eor_next;

    assign pending    = head.items & ~done_reg;
    assign sel        = pending & (~pending + 1'b1);
    assign final_item = (pending & ~sel) == '0;
    assign load       = !head_empty && (!valid_reg || out_ready);
    assign pop        = load && final_item;

    always_comb begin
        done_next   = done_reg;
        valid_next  = valid_reg && !out_ready;
        kind_next   = kind_reg;
        offs_next   = offs_reg;
        first_next  = first_reg;
        lastcp_next = lastcp_reg;
        err_next    = err_reg;
        eor_next    = eor_reg;

        if (load) begin
            valid_next  = 1'b1;
            eor_next    = final_item;
            offs_next   = '0;
            first_next  = '0;
            lastcp_next = '0;
            err_next    = ERR_PREMATURE;
            done_next   = final_item ? '0 : (done_reg | sel);
            priority if (sel[ITEM_CLOSE]) begin
                kind_next   = KIND_RANGE;
                first_next  = head.close_first;
                lastcp_next = head.close_last;
            end else if (sel[ITEM_GLYPH]) begin
                kind_next = KIND_GLYPH;
                offs_next = head.glyph_offset;
            end else if (sel[ITEM_FINAL]) begin
                kind_next   = KIND_RANGE;
                first_next  = head.final_first;
                lastcp_next = head.final_last;
            end else if (head.tail_error) begin
                kind_next = KIND_ERROR;
                err_next  = head.err_code;
            end else begin
                kind_next = KIND_TERM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        offs_reg   <= offs_next;
        first_reg  <= first_next;
        lastcp_reg <= lastcp_next;
        err_reg    <= err_next;
        eor_reg    <= eor_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = {err_reg, lastcp_reg, first_reg, offs_reg};
    assign out_kind  = kind_reg;
    assign out_last  = eor_reg;

endmodule
